// ===== rtl/core/ples_pkg.sv =====
`timescale 1ns / 1ps
// Package for the program label/END scanner.
// Parse phases, event kinds, register indexes and opcode decode constants. No dependencies.
package ples_pkg;

    typedef enum logic [2:0] {
        PH_OPCODE    = 3'd0,
        PH_SKIP      = 3'd1,
        PH_PRE_TYPE  = 3'd2,
        PH_TYPE      = 3'd3,
        PH_KEY       = 3'd4,
        PH_CHARS     = 3'd5,
        PH_EXHAUSTED = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_LBEGIN = 3'd0,
        EV_LCHAR  = 3'd1,
        EV_END    = 3'd2,
        EV_GEND   = 3'd3,
        EV_OVER   = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        CFG_CURTAIN = 2'd0,
        CFG_END     = 2'd1
    } cfg_index_t;

    localparam int          CURTAIN_W      = 10;
    localparam int          END_W          = 9;
    localparam int          CFG_W          = 10;
    localparam logic [9:0]  CURTAIN_RESET  = 10'd512;
    localparam logic [8:0]  END_RESET      = 9'd0;
    localparam logic [7:0]  OP_LABEL_MAX   = 8'hCD;
    localparam int          TYPE_LABEL_BIT = 7;
    localparam int          TYPE_GEND_BIT  = 5;
    localparam logic [2:0]  LAST_OFFSET    = 3'd6;
    localparam logic [3:0]  NIB_TWO_LO     = 4'h9;
    localparam logic [3:0]  NIB_TWO_HI     = 4'hB;
    localparam logic [3:0]  NIB_XROM       = 4'hC;
    localparam logic [3:0]  NIB_THREE_LO   = 4'hD;
    localparam logic [3:0]  NIB_THREE_HI   = 4'hE;
    localparam logic [3:0]  NIB_STRING     = 4'hF;

endpackage

// ===== rtl/core/program_label_end_scanner.sv =====
`timescale 1ns / 1ps
// Program label/END scanner top level: byte decoder, pointer tracking and result register.
// Depends on ples_pkg.
//
// Usage:
//   s_ channel: one program byte per beat in s_tdata, in program order, starting at
//   register curtain-1, offset 0.
//   m_ channel: zero or one event per input beat. m_tuser carries the event kind,
//   m_tdata the label character, m_tlast marks the beat that closes a label.
//   Config: cfg_we with cfg_index 0 writes curtain_register, 1 writes end_register;
//   either write restarts the scan. Write only while the block is idle.
//   Output: an event appears on m_ in the cycle after its byte is accepted.
//   Throughput: one byte per cycle when s_tready is high; each byte is decoded by a single
//   nibble decode and counter update between the state registers and the result register.
//   Stall: the result register holds while m_tready is low; s_tready drops only
//   when the result register is full and not being drained.
//   Reset: aresetn clears the scan state to the start of program memory with
//   curtain 512 and end register 0; no result is pending.
//   After a global END or scan-over event, further bytes are taken and dropped.
module program_label_end_scanner #(
    parameter int MEM_REGS = 512
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] program_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] label_char
    output logic [2:0]                  m_tuser,   // [2:0] event_kind
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ples_pkg::CFG_W-1:0]  cfg_wdata
);
    import ples_pkg::*;

    localparam int WIDX = $clog2(MEM_REGS);
    localparam int CW   = (WIDX > END_W) ? WIDX : END_W;

    logic [CURTAIN_W-1:0] curtain_reg, curtain_next;
    logic [END_W-1:0]     end_reg, end_next;
    phase_t               phase_reg, phase_next;
    logic [3:0]           skip_reg, skip_next;
    logic [3:0]           chars_reg, chars_next;
    logic [WIDX-1:0]      word_reg, word_next;
    logic [2:0]           offs_reg, offs_next;
    logic                 stopped_reg, stopped_next;

    logic                 out_valid_reg, out_valid_next;
    event_t               kind_reg, kind_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 emit;
    logic [CURTAIN_W-1:0] rs_curtain;
    logic [WIDX-1:0]      rs_word;
    logic                 rs_empty;
    logic [3:0]           hi_nib;
    logic [3:0]           lo_nib;
    logic [3:0]           skip_dec;
    logic [3:0]           chars_dec;
    logic                 do_advance;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign hi_nib   = s_tdata[7:4];
    assign lo_nib   = s_tdata[3:0];
    assign skip_dec  = (skip_reg != 4'd0) ? skip_reg - 4'd1 : 4'd0;
    assign chars_dec = (chars_reg != 4'd0) ? chars_reg - 4'd1 : 4'd0;

    // restart point from the curtain value in effect after this cycle
    always_comb begin
        rs_curtain = (cfg_we && cfg_index == CFG_CURTAIN) ? cfg_wdata[CURTAIN_W-1:0]
                                                          : curtain_reg;
        rs_empty   = (rs_curtain == '0);
        if (rs_empty) begin
            rs_word = '0;
        end else if (int'(rs_curtain) > MEM_REGS) begin
            rs_word = WIDX'(MEM_REGS - 1);
        end else begin
            rs_word = WIDX'(rs_curtain - 10'd1);
        end
    end

    always_comb begin
        curtain_next   = curtain_reg;
        end_next       = end_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        chars_next     = chars_reg;
        word_next      = word_reg;
        offs_next      = offs_reg;
        stopped_next   = stopped_reg;
        emit           = 1'b0;
        kind_next      = kind_reg;
        char_next      = 8'd0;
        last_next      = 1'b0;
        do_advance     = 1'b0;

        if (cfg_we && (cfg_index == CFG_CURTAIN || cfg_index == CFG_END)) begin
            if (cfg_index == CFG_CURTAIN) begin
                curtain_next = cfg_wdata[CURTAIN_W-1:0];
            end else begin
                end_next = cfg_wdata[END_W-1:0];
            end
            phase_next   = rs_empty ? PH_EXHAUSTED : PH_OPCODE;
            skip_next    = 4'd0;
            chars_next   = 4'd0;
            word_next    = rs_word;
            offs_next    = 3'd0;
            stopped_next = 1'b0;
        end else if (accept && !stopped_reg) begin
            if (phase_reg == PH_EXHAUSTED ||
                (phase_reg == PH_OPCODE && CW'(word_reg) < CW'(end_reg))) begin
                stopped_next = 1'b1;
                emit         = 1'b1;
                kind_next    = EV_OVER;
            end else begin
                do_advance = 1'b1;
                case (phase_reg)
                    PH_OPCODE: begin
                        if (hi_nib >= NIB_TWO_LO && hi_nib <= NIB_TWO_HI) begin
                            skip_next  = 4'd1;
                            phase_next = PH_SKIP;
                        end else if (hi_nib == NIB_XROM) begin
                            if (s_tdata <= OP_LABEL_MAX) begin
                                phase_next = PH_PRE_TYPE;
                            end else begin
                                skip_next  = 4'd1;
                                phase_next = PH_SKIP;
                            end
                        end else if (hi_nib == NIB_THREE_LO || hi_nib == NIB_THREE_HI) begin
                            skip_next  = 4'd2;
                            phase_next = PH_SKIP;
                        end else if (hi_nib == NIB_STRING) begin
                            skip_next  = lo_nib;
                            phase_next = (lo_nib != 4'd0) ? PH_SKIP : PH_OPCODE;
                        end
                    end
                    PH_SKIP: begin
                        skip_next  = skip_dec;
                        phase_next = (skip_dec == 4'd0) ? PH_OPCODE : PH_SKIP;
                    end
                    PH_PRE_TYPE: begin
                        phase_next = PH_TYPE;
                    end
                    PH_TYPE: begin
                        emit = 1'b1;
                        if (s_tdata[TYPE_LABEL_BIT]) begin
                            chars_next = (lo_nib != 4'd0) ? lo_nib - 4'd1 : 4'd0;
                            kind_next  = EV_LBEGIN;
                            last_next  = (lo_nib <= 4'd1);
                            phase_next = PH_KEY;
                        end else if (s_tdata[TYPE_GEND_BIT]) begin
                            kind_next    = EV_GEND;
                            stopped_next = 1'b1;
                            do_advance   = 1'b0;
                        end else begin
                            kind_next  = EV_END;
                            phase_next = PH_OPCODE;
                        end
                    end
                    PH_KEY: begin
                        phase_next = (chars_reg == 4'd0) ? PH_OPCODE : PH_CHARS;
                    end
                    PH_CHARS: begin
                        chars_next = chars_dec;
                        emit       = 1'b1;
                        kind_next  = EV_LCHAR;
                        char_next  = s_tdata;
                        last_next  = (chars_dec == 4'd0);
                        phase_next = (chars_dec == 4'd0) ? PH_OPCODE : PH_CHARS;
                    end
                    default: begin
                        phase_next = PH_OPCODE;
                    end
                endcase

                if (do_advance) begin
                    if (offs_reg == LAST_OFFSET) begin
                        if (word_reg == '0) begin
                            phase_next = PH_EXHAUSTED;
                        end else begin
                            word_next = word_reg - WIDX'(1);
                            offs_next = 3'd0;
                        end
                    end else begin
                        offs_next = offs_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        if (accept && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curtain_reg   <= CURTAIN_RESET;
            end_reg       <= END_RESET;
            phase_reg     <= PH_OPCODE;
            skip_reg      <= 4'd0;
            chars_reg     <= 4'd0;
            word_reg      <= (int'(CURTAIN_RESET) > MEM_REGS) ? WIDX'(MEM_REGS - 1)
                                                              : WIDX'(CURTAIN_RESET - 10'd1);
            offs_reg      <= 3'd0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            curtain_reg   <= curtain_next;
            end_reg       <= end_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            chars_reg     <= chars_next;
            word_reg      <= word_next;
            offs_reg      <= offs_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg <= kind_next;
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

endmodule
